// ----- hw/rtl/bmh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bmh_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_W        = 32;
	localparam int COUNT_W      = 11;

	// operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                    func;
		logic signed [KEY_W-1:0] key;
	} bmh_req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] min_value;
		status_t                 status;
		logic [COUNT_W-1:0]      count;
	} bmh_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmh_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bmh_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/binary_min_heap.sv -----
`timescale 1ns / 1ps
`default_nettype none

// binary min-heap priority queue of signed 32-bit keys, up to CAPACITY entries.
// each req transaction (insert key, or remove minimum) yields exactly one rsp
// transaction with the removed key (-1 on an empty remove, 0 on insert), a
// status (ok, remove on empty, insert on full; a full insert is dropped) and
// the entry count afterwards, reported modulo 2^11. equal keys never swap.
// the heap sits in one memory with one write port and two registered read
// ports; a small sequencer walks the tree one level at a time, with a read
// state and a compare state per level. the key moves at most log2(CAPACITY)
// levels. an empty remove or a full insert skips the walk, and a finished
// result may wait for the rsp register to free up. req is taken only while
// the sequencer is idle; a finished result waits in the rsp register while
// the next transaction is already being processed. no clearing pass after
// reset: only written entries are ever used.
module binary_min_heap
	import bmh_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bmh_stream_if.sink   req,
	bmh_stream_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SU_RD  = 8'b0000_0010,
		S_SU_CMP = 8'b0000_0100,
		S_RM_RD  = 8'b0000_1000,
		S_RM_LD  = 8'b0001_0000,
		S_SD_RD  = 8'b0010_0000,
		S_SD_CMP = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// heap storage
	logic signed [KEY_W-1:0] heap_mem [CAPACITY];
	logic signed [KEY_W-1:0] rd0_q, rd1_q;

	logic                    mem_we;
	logic [AW-1:0]           mem_wa, mem_ra0, mem_ra1;
	logic signed [KEY_W-1:0] mem_wd;

	// walk registers
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           pos_q;
	logic signed [KEY_W-1:0] key_q;      // key being moved through the tree
	logic signed [KEY_W-1:0] res_value_q;
	status_t                 res_status_q;

	// rsp register
	logic     out_valid_q;
	bmh_rsp_t out_q;

	// tree arithmetic
	logic [AW:0]   lchild, rchild;
	logic [AW-1:0] parent;
	logic [XW-1:0] count_ext;
	logic          l_ok, r_ok;
	logic          pick_right;
	logic [AW-1:0] pick_idx;
	logic signed [KEY_W-1:0] pick_val;
	logic [CW-1:0] count_dec;
	logic [CW+COUNT_W-1:0] count_wide;
	logic          req_fire, out_free;

	assign lchild    = {pos_q, 1'b1};
	assign rchild    = lchild + 1'b1;
	assign parent    = (pos_q - 1'b1) >> 1;
	assign count_ext = XW'(count_q);
	assign l_ok      = XW'(lchild) < count_ext;
	assign r_ok      = XW'(rchild) < count_ext;
	assign count_dec = count_q - 1'b1;

	// right child wins only when strictly smaller
	assign pick_right = r_ok && (rd1_q < rd0_q);
	assign pick_idx   = pick_right ? rchild[AW-1:0] : lchild[AW-1:0];
	assign pick_val   = pick_right ? rd1_q : rd0_q;

	assign count_wide = (CW + COUNT_W)'(count_q);

	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// memory port control
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = pos_q;
		mem_wd  = key_q;
		mem_ra0 = parent;
		mem_ra1 = parent;
		unique case (state_q)
			S_SU_RD: begin
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end
			end
			S_SU_CMP: begin
				mem_we = 1'b1;
				if (key_q < rd0_q) begin
					mem_wd = rd0_q;
				end
			end
			S_RM_RD: begin
				mem_ra0 = '0;
				mem_ra1 = count_dec[AW-1:0];
			end
			S_SD_RD: begin
				mem_ra0 = lchild[AW-1:0];
				mem_ra1 = r_ok ? rchild[AW-1:0] : lchild[AW-1:0];
				if (!l_ok) begin
					mem_we = 1'b1;
				end
			end
			S_SD_CMP: begin
				mem_we = 1'b1;
				if (key_q > pick_val) begin
					mem_wd = pick_val;
				end
			end
			S_IDLE, S_RM_LD, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem[mem_wa] <= mem_wd;
		end
		rd0_q <= heap_mem[mem_ra0];
		rd1_q <= heap_mem[mem_ra1];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			pos_q        <= '0;
			key_q        <= '0;
			res_value_q  <= '0;
			res_status_q <= ST_OK;
		end else begin
			// rsp register: load a finished result, or free it once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						res_value_q  <= '0;
						res_status_q <= ST_OK;
						if (req.data.func == FUNC_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								// full: drop the key
								res_status_q <= ST_FULL;
								state_q      <= S_DONE;
							end else begin
								key_q   <= req.data.key;
								pos_q   <= count_q[AW-1:0];
								count_q <= count_q + 1'b1;
								state_q <= S_SU_RD;
							end
						end else begin
							if (count_q == '0) begin
								res_value_q  <= -32'sd1;
								res_status_q <= ST_EMPTY;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_RM_RD;
							end
						end
					end
				end
				S_SU_RD: begin
					state_q <= (pos_q == '0) ? S_DONE : S_SU_CMP;
				end
				S_SU_CMP: begin
					// move the parent down into the hole, or settle the key
					if (key_q < rd0_q) begin
						pos_q   <= parent;
						state_q <= S_SU_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RM_RD: begin
					state_q <= S_RM_LD;
				end
				S_RM_LD: begin
					res_value_q <= rd0_q;
					key_q       <= rd1_q;
					pos_q       <= '0;
					count_q     <= count_dec;
					state_q     <= S_SD_RD;
				end
				S_SD_RD: begin
					state_q <= l_ok ? S_SD_CMP : S_DONE;
				end
				S_SD_CMP: begin
					if (key_q > pick_val) begin
						pos_q   <= pick_idx;
						state_q <= S_SD_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// wait for the rsp register to free up
					if (out_free) begin
						out_q.min_value <= res_value_q;
						out_q.status    <= res_status_q;
						out_q.count     <= count_wide[COUNT_W-1:0];
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// entry count never exceeds the capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// an empty remove goes straight to the result with empty status
	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.data.func == FUNC_REMOVE && count_q == '0)
		|=> (state_q == S_DONE && res_status_q == ST_EMPTY && res_value_q == -32'sd1))
		else $error("empty remove not flagged");

	// writes stay inside the live part of the heap
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (XW'(mem_wa) < count_ext || mem_wa == '0))
		else $error("heap write beyond entry count");

	// a result is never overwritten before it is taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending result lost");

endmodule

`default_nettype wire

// ----- test/binary_min_heap_checker.sv -----
`timescale 1ns / 1ps

// watches both channels, keeps its own heap and compares every rsp transaction
module binary_min_heap_checker
	import bmh_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_ready,
	input  bmh_req_t req_data,
	input  logic     rsp_valid,
	input  logic     rsp_ready,
	input  bmh_rsp_t rsp_data,
	output int       mismatches,
	output int       outstanding,
	output int       held
);

	logic signed [KEY_W-1:0] heap_keys [CAPACITY];
	int                      key_total = 0;
	bmh_rsp_t                awaited_rsp [$];
	int                      fail_total = 0;
	int                      pending_total = 0;

	assign mismatches  = fail_total;
	assign outstanding = pending_total;
	assign held        = key_total;

	function automatic void swap_keys(input int a, input int b);
		logic signed [KEY_W-1:0] t;
		t = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	// applies one transaction to the heap copy and returns the response it causes
	function automatic bmh_rsp_t heap_outcome(input bmh_req_t op);
		bmh_rsp_t outcome;
		int       slot;
		int       parent;
		int       left;
		int       right;
		int       pick;
		outcome.min_value = '0;
		outcome.status    = ST_OK;
		if (op.func == FUNC_INSERT) begin
			if (key_total >= CAPACITY) begin
				outcome.status = ST_FULL;
			end else begin
				slot = key_total;
				heap_keys[slot] = op.key;
				key_total++;
				// sift up, strict compare so equal keys stay put
				while (slot > 0) begin
					parent = (slot - 1) / 2;
					if (heap_keys[slot] < heap_keys[parent]) begin
						swap_keys(slot, parent);
						slot = parent;
					end else begin
						break;
					end
				end
			end
		end else if (key_total == 0) begin
			outcome.min_value = -1;
			outcome.status    = ST_EMPTY;
		end else begin
			outcome.min_value = heap_keys[0];
			heap_keys[0] = heap_keys[key_total-1];
			key_total--;
			slot = 0;
			// sift down, right child only when strictly smaller than left
			forever begin
				left  = 2 * slot + 1;
				right = left + 1;
				if (left >= key_total) break;
				pick = left;
				if (right < key_total && heap_keys[right] < heap_keys[left]) pick = right;
				if (heap_keys[slot] > heap_keys[pick]) begin
					swap_keys(slot, pick);
					slot = pick;
				end else begin
					break;
				end
			end
		end
		outcome.count = COUNT_W'(key_total);
		return outcome;
	endfunction

	task automatic flag_field(input string field, input longint want, input longint got);
		fail_total++;
		$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		bmh_rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				awaited_rsp.push_back(heap_outcome(req_data));
			end
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					fail_total++;
					$display({"%0t: expected no transaction, ",
						"actual min_value %0d status %0d count %0d"},
						$time, rsp_data.min_value, rsp_data.status, rsp_data.count);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp_data.min_value !== want.min_value)
						flag_field("min_value", want.min_value, rsp_data.min_value);
					if (rsp_data.status !== want.status)
						flag_field("status", want.status, rsp_data.status);
					if (rsp_data.count !== want.count)
						flag_field("count", want.count, rsp_data.count);
				end
			end
			pending_total = awaited_rsp.size();
		end
	end

endmodule

// ----- test/binary_min_heap_tb.sv -----
`timescale 1ns / 1ps

// stimulus and verdict for the heap; all comparing is done in the checker
module binary_min_heap_tb
	import bmh_pkg::*;
;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 5;
	// far beyond the longest item plus receiver stalls
	localparam int STALL_LIMIT  = 2000;
	// tail wait after the last response
	localparam int DRAIN_CYCLES = 60;
	localparam int GAP_PCT      = 14;
	localparam int MIXED_ITEMS  = 30;
	localparam int STEADY_ITEMS = 300;
	localparam int FULL_ITEMS   = 20;
	localparam int FILL_PCT     = 99;

	logic clk     = 1'b0;
	logic arst_n  = 1'b0;
	// when set, neither side idles
	logic no_gaps = 1'b0;

	int mismatches;
	int outstanding;
	int held;
	int stall_cycles = 0;
	int fill_items   = 0;

	bmh_stream_if #(.payload_t(bmh_req_t)) req ();
	bmh_stream_if #(.payload_t(bmh_rsp_t)) rsp ();

	binary_min_heap #(
		.CAPACITY(CAPACITY_DEF)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	binary_min_heap_checker #(
		.CAPACITY(CAPACITY_DEF)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_data   (req.data),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_data   (rsp.data),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.held       (held)
	);

	always #HALF_PERIOD clk = ~clk;

	// receiver side: ready changes on the falling edge, stalls at random
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
		end
	end

	// watchdog: ends the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// keys: full range, a tight band so equal keys are common, and the extremes
	function automatic logic signed [KEY_W-1:0] random_key();
		logic signed [KEY_W-1:0] k;
		case ($urandom_range(5))
			0, 1: k = $urandom;
			2, 3: k = KEY_W'($urandom_range(7)) - KEY_W'(4);
			4: begin
				case ($urandom_range(3))
					0: k = 32'sh7FFF_FFFF;
					1: k = 32'sh8000_0000;
					2: k = '0;
					default: k = -1;
				endcase
			end
			default: k = KEY_W'($urandom_range(200)) - KEY_W'(100);
		endcase
		return k;
	endfunction

	// presents one transaction at the falling edge and returns on the falling edge
	// after it is taken; valid is left high so the next call can follow directly
	task automatic issue(input logic func, input logic signed [KEY_W-1:0] key);
		if (!no_gaps) begin
			while ($urandom_range(99) < GAP_PCT) begin
				req.valid <= 1'b0;
				@(negedge clk);
			end
		end
		req.valid     <= 1'b1;
		req.data.func <= func;
		req.data.key  <= key;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic issue_random(input int insert_pct);
		issue(($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE, random_key());
	endtask

	initial begin
		req.valid = 1'b0;
		req.data  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// remove on an empty heap, key bits are ignored
		issue(FUNC_REMOVE, -1);
		// extremes, zero, minus one and a run of equal keys
		issue(FUNC_INSERT, 32'sh7FFF_FFFF);
		issue(FUNC_INSERT, 32'sh8000_0000);
		issue(FUNC_INSERT, '0);
		issue(FUNC_INSERT, -1);
		issue(FUNC_INSERT, 7);
		issue(FUNC_INSERT, 7);
		issue(FUNC_INSERT, 7);
		issue(FUNC_INSERT, -1);
		repeat (8) issue(FUNC_REMOVE, random_key());
		issue(FUNC_REMOVE, 32'sh5555_AAAA);
		// equal keys on the way down
		repeat (3) issue(FUNC_INSERT, 3);
		repeat (2) issue(FUNC_REMOVE, '0);

		// small heaps with frequent empty removes
		repeat (MIXED_ITEMS) issue_random(50);

		// hold off until every response is in
		req.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);

		// grow to full depth, first stretch with no idling on either side
		while (held < CAPACITY_DEF) begin
			no_gaps <= (fill_items < STEADY_ITEMS);
			issue_random(FILL_PCT);
			fill_items++;
		end
		no_gaps <= 1'b0;

		// churn at capacity: dropped inserts and deep sift-downs
		repeat (FULL_ITEMS) issue_random(65);

		req.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/bmh_pkg.sv
hw/rtl/bmh_stream_if.sv
hw/rtl/binary_min_heap.sv
test/binary_min_heap_checker.sv
test/binary_min_heap_tb.sv
